[rtl/fatm_pkg.sv]
// Shared types and constants of the frame arrival timing monitor.
`timescale 1ns / 1ps

package fatm_pkg;

  // Operand width of the shared subtractor and width of its result.
  localparam int unsigned AluW = 49;
  localparam int unsigned ResW = AluW + 1;

  // Fixed-point rate numerator: 1000 ms per second times 256 (Q.8).
  localparam int unsigned QuotBits = 18;
  localparam logic [QuotBits-1:0] RateNum = 18'd256000;

  // Reset value of the stale threshold register, in milliseconds.
  localparam logic [15:0] ThrReset = 16'd1000;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_FRAME   = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_e;

  // One input item.
  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] now_ms;
    logic [31:0] camera_timestamp_ms;
  } in_item_t;

  // One result item: the whole status.
  typedef struct packed {
    logic        has_frame;
    logic        receiving;
    logic        stale;
    logic        arrival_interval_valid;
    logic [31:0] arrival_interval_ms;
    logic        camera_interval_valid;
    logic [31:0] camera_interval_ms;
    logic [17:0] frame_rate_q8;
  } out_item_t;

  // Operands handed from the sequencer to the shared subtractor.
  typedef struct packed {
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
  } alu_op_t;

endpackage

[rtl/fatm_alu.sv]
// Shared signed subtractor used for every difference, compare and divide step.
`timescale 1ns / 1ps

module fatm_alu
  import fatm_pkg::*;
(
  input  alu_op_t                op_i,
  output logic signed [ResW-1:0] diff_o
);

  // One wide subtract; the sign bit of the result serves as the compare.
  assign diff_o = ResW'(op_i.a) - ResW'(op_i.b);

endmodule

[rtl/fatm_seq.sv]
// Sequencer and status state of the frame arrival timing monitor.
`timescale 1ns / 1ps

module fatm_seq
  import fatm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              status_o,
  input  logic [15:0]            thr_i,
  output alu_op_t                alu_op_o,
  input  logic signed [ResW-1:0] alu_diff_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOCAL = 7'b0000010,
    S_DELTA = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_CAM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  localparam int unsigned CntW = $clog2(QuotBits);

  state_e state_q, state_d;

  // Latched item and working values.
  logic [1:0]               func_q;
  logic [47:0]              now_q;
  logic [31:0]              stamp_q;
  logic [47:0]              local_q;
  logic [AluW-1:0]          delta_q;
  logic [QuotBits-1:0]      rem_q;
  logic [CntW-1:0]          cnt_q;
  logic                     div_q;

  // Monitor state.
  logic [47:0]              base_q;
  logic [47:0]              last_q;
  logic [31:0]              lastcam_q;
  logic                     seen_q;
  logic                     rcv_q;
  logic                     stale_q;
  logic                     avalid_q;
  logic [31:0]              aint_q;
  logic                     cvalid_q;
  logic [31:0]              cint_q;
  logic [QuotBits-1:0]      rate_q;

  logic                     res_pos;
  logic                     res_neg;

  assign res_neg = alu_diff_i[ResW-1];
  assign res_pos = !res_neg && (alu_diff_i != '0);

  // Operand selection for the shared subtractor.
  always_comb begin
    alu_op_o = '0;
    case (state_q)
      S_LOCAL: begin
        alu_op_o.a = AluW'(now_q);
        alu_op_o.b = AluW'(base_q);
      end
      S_DELTA: begin
        alu_op_o.a = AluW'(local_q);
        alu_op_o.b = AluW'(last_q);
      end
      S_CMP: begin
        alu_op_o.a = AluW'(thr_i);
        alu_op_o.b = delta_q;
      end
      S_CAM: begin
        alu_op_o.a = AluW'(stamp_q);
        alu_op_o.b = AluW'(lastcam_q);
      end
      S_DIV: begin
        alu_op_o.a = AluW'({rem_q, RateNum[cnt_q]});
        alu_op_o.b = AluW'(delta_q[QuotBits-1:0]);
      end
      default: begin
        alu_op_o = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOCAL;
      end
      S_LOCAL: begin
        case (func_q)
          FUNC_FRAME:   state_d = (seen_q && !stale_q) ? S_DELTA : S_OUT;
          FUNC_REFRESH: state_d = seen_q ? S_DELTA : S_OUT;
          default:      state_d = S_OUT;
        endcase
      end
      S_DELTA: begin
        state_d = (func_q == FUNC_REFRESH) ? S_CMP : S_CAM;
      end
      S_CMP: begin
        state_d = S_OUT;
      end
      S_CAM: begin
        state_d = div_q ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (cnt_q == '0) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Item capture and working registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q  <= in_data_i.func;
      now_q   <= in_data_i.now_ms;
      stamp_q <= in_data_i.camera_timestamp_ms;
    end
    if (state_q == S_LOCAL) begin
      local_q <= alu_diff_i[47:0];
    end
    if (state_q == S_DELTA) begin
      delta_q <= alu_diff_i[AluW-1:0];
    end
    if (state_q == S_CAM) begin
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      if (!res_neg) begin
        rem_q <= alu_diff_i[QuotBits-1:0];
      end else begin
        rem_q <= {rem_q[QuotBits-2:0], RateNum[cnt_q]};
      end
    end
  end

  // Sequencer state and monitor status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      div_q     <= 1'b0;
      base_q    <= '0;
      last_q    <= '0;
      lastcam_q <= '0;
      seen_q    <= 1'b0;
      rcv_q     <= 1'b0;
      stale_q   <= 1'b0;
      avalid_q  <= 1'b0;
      aint_q    <= '0;
      cvalid_q  <= 1'b0;
      cint_q    <= '0;
      rate_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        // Local time is ready; handle clear, re-arm and the no-frame check here.
        S_LOCAL: begin
          case (func_q)
            FUNC_FRAME: begin
              if (!seen_q || stale_q) begin
                seen_q    <= 1'b1;
                rcv_q     <= 1'b1;
                stale_q   <= 1'b0;
                avalid_q  <= 1'b0;
                aint_q    <= '0;
                cvalid_q  <= 1'b0;
                cint_q    <= '0;
                rate_q    <= '0;
                last_q    <= alu_diff_i[47:0];
                lastcam_q <= stamp_q;
              end
            end
            FUNC_REFRESH: begin
              if (!seen_q) begin
                rcv_q   <= 1'b0;
                stale_q <= 1'b0;
              end
            end
            FUNC_CLEAR: begin
              base_q    <= now_q;
              last_q    <= '0;
              lastcam_q <= '0;
              seen_q    <= 1'b0;
              rcv_q     <= 1'b0;
              stale_q   <= 1'b0;
              avalid_q  <= 1'b0;
              aint_q    <= '0;
              cvalid_q  <= 1'b0;
              cint_q    <= '0;
              rate_q    <= '0;
            end
            default: begin
            end
          endcase
        end
        // Arrival interval of a frame; a refresh only keeps the difference.
        S_DELTA: begin
          if (func_q == FUNC_FRAME) begin
            avalid_q <= res_pos;
            rate_q   <= '0;
            div_q    <= res_pos && (alu_diff_i[AluW-1:QuotBits] == '0);
            if (!res_pos) begin
              aint_q <= '0;
            end else if (alu_diff_i[AluW-1:32] != '0) begin
              aint_q <= '1;
            end else begin
              aint_q <= alu_diff_i[31:0];
            end
          end
        end
        // Threshold compare: a negative threshold minus age means stale.
        S_CMP: begin
          rcv_q   <= !res_neg;
          stale_q <= res_neg;
          if (res_neg) begin
            avalid_q <= 1'b0;
            aint_q   <= '0;
            cvalid_q <= 1'b0;
            cint_q   <= '0;
            rate_q   <= '0;
          end
        end
        // Camera interval and the update of the previous frame values.
        S_CAM: begin
          cvalid_q  <= res_pos;
          cint_q    <= res_pos ? alu_diff_i[31:0] : '0;
          last_q    <= local_q;
          lastcam_q <= stamp_q;
          rcv_q     <= 1'b1;
          stale_q   <= 1'b0;
          cnt_q     <= CntW'(QuotBits - 1);
        end
        // One restoring divide step per cycle, quotient shifted into the rate.
        S_DIV: begin
          rate_q <= {rate_q[QuotBits-2:0], !res_neg};
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  assign status_o.has_frame              = seen_q;
  assign status_o.receiving              = rcv_q;
  assign status_o.stale                  = stale_q;
  assign status_o.arrival_interval_valid = avalid_q;
  assign status_o.arrival_interval_ms    = aint_q;
  assign status_o.camera_interval_valid  = cvalid_q;
  assign status_o.camera_interval_ms     = cint_q;
  assign status_o.frame_rate_q8          = rate_q;

endmodule

[rtl/frame_arrival_timing_monitor.sv]
// Top level of the frame arrival timing monitor.
`timescale 1ns / 1ps

// Frame arrival timing monitor. Each input item is a frame arrival, a
// freshness check or a clear, and each gives exactly one status result. A
// single 49-bit subtractor does all the work under a small sequencer: local
// time, arrival interval, threshold compare, camera interval, and a restoring
// divide of 256000 by the interval at one quotient bit per cycle. A clear, or
// a check before any frame, goes from the local time step straight to the
// result; a frame with an interval below 262144 ms ends with the 18 divide
// steps. An item holds the block until its result is taken on out_ready_i;
// the next item is taken the cycle after the result transfer. The stale
// threshold register is written through its own channel, which is always ready.
module frame_arrival_timing_monitor
  import fatm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [15:0]            thr_q;
  alu_op_t                alu_op;
  logic signed [ResW-1:0] alu_diff;

  // Stale threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Shared arithmetic unit.
  fatm_alu u_alu (
    .op_i   (alu_op),
    .diff_o (alu_diff)
  );

  // Sequencer and status.
  fatm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (out_data_o),
    .thr_i       (thr_q),
    .alu_op_o    (alu_op),
    .alu_diff_i  (alu_diff)
  );

endmodule

[rtl/fatm_checker.sv]
// Port-level checks of the frame arrival timing monitor and their binding.
`timescale 1ns / 1ps

module fatm_checker
  import fatm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // After an input transfer the block is busy in the next cycle.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // No new item is taken while a result is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // A clear always returns an empty status.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.func == FUNC_CLEAR) |=> ##1
    (out_valid_o && !out_data_o.has_frame && !out_data_o.receiving &&
     !out_data_o.stale && (out_data_o.frame_rate_q8 == '0)))
    else $error("clear did not empty the status");

  // An invalid arrival interval carries no interval and no rate.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.arrival_interval_valid |->
    (out_data_o.arrival_interval_ms == '0) && (out_data_o.frame_rate_q8 == '0))
    else $error("invalid interval with nonzero value");

endmodule

bind frame_arrival_timing_monitor fatm_checker u_fatm_checker (.*);
